// File: hw/rtl/ryuv_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ryuv_pkg
// Shared types and constants for the RGB to YUV 4:2:0 stream converter.
// ============================================================================
package ryuv_pkg;

    // Configuration register width and the width used for size arithmetic.
    localparam int CFG_W  = 13;
    localparam int SIZE_W = CFG_W + 1;

    // Default frame limits.
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Register reset values.
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd3840;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd2160;

    // Register indexes.
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Width of the fixed-point accumulators.
    localparam int ACC_W = 25;

    // BT.601 studio-range coefficients in Q16.
    localparam logic [15:0] K_YR = 16'd16843;
    localparam logic [15:0] K_YG = 16'd33030;
    localparam logic [15:0] K_YB = 16'd6423;
    localparam logic [15:0] K_UR = 16'd9699;
    localparam logic [15:0] K_UG = 16'd19071;
    localparam logic [15:0] K_UB = 16'd28770;
    localparam logic [15:0] K_VR = 16'd28770;
    localparam logic [15:0] K_VG = 16'd24117;
    localparam logic [15:0] K_VB = 16'd4653;

    // Offsets of 16 and 128 in Q16.
    localparam logic [ACC_W-1:0] OFF_Y = 25'd1048576;
    localparam logic [ACC_W-1:0] OFF_C = 25'd8388608;

    // One input pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_in_t;

    // One converted pixel.
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] u_full;
        logic [7:0] v_full;
        logic       chroma_valid;
        logic [7:0] u_sub;
        logic [7:0] v_sub;
        logic       frame_end;
    } pix_out_t;

    // Constant coefficient times an 8-bit component.
    function automatic logic [ACC_W-1:0] mul_k(input logic [15:0] k, input logic [7:0] x);
        mul_k = ACC_W'(k) * ACC_W'(x);
    endfunction

endpackage

// File: hw/rtl/rgb_to_yuv420_stream.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb_to_yuv420_stream
// Raster-order RGB to BT.601 studio-range YUV with 4:2:0 chroma averaging.
// ============================================================================
// The block takes one RGB pixel per clock while the output side is not
// stalled and returns one result per pixel. An accepted pixel passes through
// stage A, stage B and the output register before it is presented. Each
// result carries Y, U and V of the pixel and, on odd rows at odd columns, the
// floored mean U and V of the 2x2 block that the pixel completes. The
// sustained rate is one pixel per cycle while the output is not stalled; it
// is set by the fixed-point multiply-add stage and by the line store, which
// can take a read and a write in the same cycle. The line store holds
// MAX_WIDTH/2 entries of 18 bits (the top-row U and V pair sums) and is not
// cleared after reset: the first even row of a frame fills it before any odd
// row reads it, so the block accepts pixels right out of reset. The frame
// size comes from the two configuration registers; their low bits are
// ignored, and sizes are held between 2 and the MAX_WIDTH and MAX_HEIGHT
// parameters. Write the registers only while no request is in flight.
module rgb_to_yuv420_stream
    import ryuv_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_we,
    input  cfg_reg_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,

    input  logic             in_valid,
    output logic             in_ready,
    input  pix_in_t          in_data,

    output logic             out_valid,
    input  logic             out_ready,
    output pix_out_t         out_data
);

    // Column and row counter widths; the column address into the line store
    // drops the low column bit.
    localparam int CW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int RW         = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW         = CW - 1;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    localparam logic [SIZE_W-1:0] MAX_W_S = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_S = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] MIN_S   = SIZE_W'(2);

    // Clears the low bit and clamps to the legal range.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] r,
                                                   input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] s;
        s = {1'b0, r[CFG_W-1:1], 1'b0};
        if (s < MIN_S)
        begin
            s = MIN_S;
        end
        if (s > lim)
        begin
            s = lim;
        end
        eff_size = s;
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;

    // Raster position of the next pixel.
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // Stage A: the accepted pixel and its position flags.
    logic          a_vld_reg, a_vld_next;
    pix_in_t       a_pix_reg, a_pix_next;
    logic          a_codd_reg, a_codd_next;
    logic          a_rodd_reg, a_rodd_next;
    logic [AW-1:0] a_idx_reg, a_idx_next;
    logic          a_fend_reg, a_fend_next;

    // Stage B: converted Y, U, V and the line store read data.
    logic          b_vld_reg, b_vld_next;
    logic [7:0]    b_y_reg, b_y_next;
    logic [7:0]    b_u_reg, b_u_next;
    logic [7:0]    b_v_reg, b_v_next;
    logic          b_codd_reg, b_codd_next;
    logic          b_rodd_reg, b_rodd_next;
    logic [AW-1:0] b_idx_reg, b_idx_next;
    logic          b_fend_reg, b_fend_next;
    logic [17:0]   top_reg;

    // Stage C: the output register.
    logic          out_vld_reg, out_vld_next;
    pix_out_t      out_reg, out_next;

    // U and V of the last even-column pixel.
    logic [7:0]    left_u_reg, left_u_next;
    logic [7:0]    left_v_reg, left_v_next;

    // Top-row pair sums: U in bits 8:0, V in bits 17:9.
    logic [17:0]   line_mem [LINE_DEPTH];

    logic              en_a, en_b, en_c, accept;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [SIZE_W-1:0] cur_col, cur_row, nxt_col, nxt_row;
    logic [ACC_W-1:0]  y_acc, u_acc, v_acc;
    logic [8:0]        pair_u, pair_v;
    logic [9:0]        sum_u, sum_v;
    logic              line_we;

    // Each stage moves when the stage after it is empty or moving.
    assign en_c      = !out_vld_reg || out_ready;
    assign en_b      = !b_vld_reg || en_c;
    assign en_a      = !a_vld_reg || en_b;
    assign in_ready  = en_a;
    assign accept    = in_valid && en_a;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    assign w_eff = eff_size(width_reg, MAX_W_S);
    assign h_eff = eff_size(height_reg, MAX_H_S);

    // Position of the incoming pixel, wrapping counters that a size change
    // left beyond the frame, and the position that follows it.
    always_comb
    begin
        cur_col = SIZE_W'(col_reg);
        cur_row = SIZE_W'(row_reg);
        if (cur_col >= w_eff)
        begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
        end
        if (cur_row >= h_eff)
        begin
            cur_row = '0;
        end
        nxt_col = cur_col + 1'b1;
        nxt_row = cur_row;
        if (nxt_col >= w_eff)
        begin
            nxt_col = '0;
            nxt_row = cur_row + 1'b1;
            if (nxt_row >= h_eff)
            begin
                nxt_row = '0;
            end
        end
    end

    // Q16 multiply-add; every sum is known to be non-negative, so the
    // subtractions never wrap and the floor is a plain bit-select.
    always_comb
    begin
        y_acc = mul_k(K_YR, a_pix_reg.red) + mul_k(K_YG, a_pix_reg.green)
              + mul_k(K_YB, a_pix_reg.blue) + OFF_Y;
        u_acc = mul_k(K_UB, a_pix_reg.blue) + OFF_C
              - mul_k(K_UR, a_pix_reg.red) - mul_k(K_UG, a_pix_reg.green);
        v_acc = mul_k(K_VR, a_pix_reg.red) + OFF_C
              - mul_k(K_VG, a_pix_reg.green) - mul_k(K_VB, a_pix_reg.blue);
    end

    // Pair sums for the line store and the 2x2 block sums.
    always_comb
    begin
        pair_u  = 9'(left_u_reg) + 9'(b_u_reg);
        pair_v  = 9'(left_v_reg) + 9'(b_v_reg);
        sum_u   = 10'(top_reg[8:0]) + 10'(pair_u);
        sum_v   = 10'(top_reg[17:9]) + 10'(pair_v);
        line_we = en_c && b_vld_reg && b_codd_reg && !b_rodd_reg;
    end

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        col_next     = col_reg;
        row_next     = row_reg;

        a_vld_next   = a_vld_reg;
        a_pix_next   = a_pix_reg;
        a_codd_next  = a_codd_reg;
        a_rodd_next  = a_rodd_reg;
        a_idx_next   = a_idx_reg;
        a_fend_next  = a_fend_reg;

        b_vld_next   = b_vld_reg;
        b_y_next     = b_y_reg;
        b_u_next     = b_u_reg;
        b_v_next     = b_v_reg;
        b_codd_next  = b_codd_reg;
        b_rodd_next  = b_rodd_reg;
        b_idx_next   = b_idx_reg;
        b_fend_next  = b_fend_reg;

        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        left_u_next  = left_u_reg;
        left_v_next  = left_v_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          width_next  = width_reg;
            endcase
        end

        if (en_a)
        begin
            a_vld_next = in_valid;
        end
        if (accept)
        begin
            col_next    = nxt_col[CW-1:0];
            row_next    = nxt_row[RW-1:0];
            a_pix_next  = in_data;
            a_codd_next = cur_col[0];
            a_rodd_next = cur_row[0];
            a_idx_next  = cur_col[CW-1:1];
            a_fend_next = (cur_col == w_eff - 1'b1) && (cur_row == h_eff - 1'b1);
        end

        if (en_b)
        begin
            b_vld_next  = a_vld_reg;
            b_y_next    = y_acc[23:16];
            b_u_next    = u_acc[23:16];
            b_v_next    = v_acc[23:16];
            b_codd_next = a_codd_reg;
            b_rodd_next = a_rodd_reg;
            b_idx_next  = a_idx_reg;
            b_fend_next = a_fend_reg;
        end

        if (en_c)
        begin
            out_vld_next          = b_vld_reg;
            out_next.luma         = b_y_reg;
            out_next.u_full       = b_u_reg;
            out_next.v_full       = b_v_reg;
            out_next.frame_end    = b_fend_reg;
            out_next.chroma_valid = b_codd_reg && b_rodd_reg;
            out_next.u_sub        = '0;
            out_next.v_sub        = '0;
            if (b_codd_reg && b_rodd_reg)
            begin
                out_next.u_sub = sum_u[9:2];
                out_next.v_sub = sum_v[9:2];
            end
            if (b_vld_reg && !b_codd_reg)
            begin
                left_u_next = b_u_reg;
                left_v_next = b_v_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            left_u_reg  <= '0;
            left_v_reg  <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_vld_reg   <= a_vld_next;
            b_vld_reg   <= b_vld_next;
            out_vld_reg <= out_vld_next;
            left_u_reg  <= left_u_next;
            left_v_reg  <= left_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_pix_reg  <= a_pix_next;
        a_codd_reg <= a_codd_next;
        a_rodd_reg <= a_rodd_next;
        a_idx_reg  <= a_idx_next;
        a_fend_reg <= a_fend_next;
        b_y_reg    <= b_y_next;
        b_u_reg    <= b_u_next;
        b_v_reg    <= b_v_next;
        b_codd_reg <= b_codd_next;
        b_rodd_reg <= b_rodd_next;
        b_idx_reg  <= b_idx_next;
        b_fend_reg <= b_fend_next;
        out_reg    <= out_next;
    end

    // Line store. The read for a pixel is issued as it moves into stage B
    // and the write of the top-row pair sum as its pixel leaves stage B.
    // The pixel that reads an entry is at least two pixels behind the one
    // that wrote it, so the write has always landed before the read is
    // issued and no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            top_reg <= line_mem[a_idx_reg];
        end
        if (line_we)
        begin
            line_mem[b_idx_reg] <= {pair_v, pair_u};
        end
    end

endmodule
